/* hdl/grid_dfs_step_walker_macros.svh */
`ifndef GRID_DFS_STEP_WALKER_MACROS_SVH
`define GRID_DFS_STEP_WALKER_MACROS_SVH

// same-cycle implication, off while reset is high
`define GDW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gdw: invariant violated");

// implication in the next cycle, off while reset is high
`define GDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gdw: sequence violated");

`endif

/* hdl/gdw_pkg.sv */
`default_nettype none

package gdw_pkg;

  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 16;

  localparam int OP_W  = 2;
  localparam int IDX_W = 9;
  localparam int SX_W  = 5;
  localparam int SY_W  = 4;
  localparam int OUT_W = 9;
  localparam int DIR_W = 3;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  // neighbour order tried by the walk, then the exhausted mark
  localparam logic [DIR_W-1:0] DIR_N   = 3'd0;
  localparam logic [DIR_W-1:0] DIR_S   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_W_  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_E   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_END = 3'd4;

  typedef enum logic [1:0] {
    RD_LOAD  = 2'd0,
    RD_START = 2'd1,
    RD_NB    = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    cap;
    logic    clr_open;
    logic    clr_vis;
    logic    clr_step;
    rd_sel_t rd_sel;
    logic    ld_commit;
    logic    st_init;
    logic    st_commit;
    logic    dir_init;
    logic    dir_inc;
    logic    push_commit;
    logic    pop_issue;
    logic    pop_load;
    logic    finish;
    logic    out_load;
  } gdw_cmd_t;

  typedef struct packed {
    logic ld_in_range;
    logic clr_last;
    logic done_cond;
    logic dir_end;
    logic depth_one;
    logic nb_in_range;
    logic nb_free;
    logic unv_zero;
    logic out_free;
  } gdw_status_t;

endpackage

`default_nettype wire

/* hdl/grid_dfs_step_walker.sv */
// load item: read in S_LD_RD, written in S_LD_WR; an index off the grid is dropped in idle
// start item: a sweep of the visited marks, one entry a cycle, then the start cell is read and checked
// next item: a neighbour on the grid is read in S_NX_RD and checked in S_NX_EV; an off-grid one is
// skipped in S_NX_RD; a result still waiting in the output register holds the item until out_ready
// reset: synchronous; a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells zeroes the cell maps
// and holds in_ready low, after which the walk is finished and the stack empty
`default_nettype none

module grid_dfs_step_walker #(
  parameter int GRID_WIDTH  = gdw_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gdw_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [gdw_pkg::OP_W-1:0]   opcode,
  input  wire logic [gdw_pkg::IDX_W-1:0]  cell_index,
  input  wire logic                       cell_open,
  input  wire logic [gdw_pkg::SX_W-1:0]   start_x,
  input  wire logic [gdw_pkg::SY_W-1:0]   start_y,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [gdw_pkg::OUT_W-1:0]       step_cell,
  output logic                            done_res
);

  gdw_pkg::gdw_cmd_t    cmd;
  gdw_pkg::gdw_status_t status;

  gdw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  gdw_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cell_index (cell_index),
    .cell_open  (cell_open),
    .start_x    (start_x),
    .start_y    (start_y),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .step_cell  (step_cell),
    .done_res   (done_res)
  );

endmodule

`default_nettype wire

/* hdl/gdw_ram.sv */
`default_nettype none

module gdw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/gdw_ctrl.sv */
`default_nettype none

module gdw_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [gdw_pkg::OP_W-1:0]      opcode,
  input  wire gdw_pkg::gdw_status_t          status,
  output logic                               in_ready,
  output gdw_pkg::gdw_cmd_t                  cmd
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_LD_RD  = 12'b0000_0000_0100,
    S_LD_WR  = 12'b0000_0000_1000,
    S_ST_CLR = 12'b0000_0001_0000,
    S_ST_RD  = 12'b0000_0010_0000,
    S_ST_EV  = 12'b0000_0100_0000,
    S_NX_CHK = 12'b0000_1000_0000,
    S_NX_RD  = 12'b0001_0000_0000,
    S_NX_EV  = 12'b0010_0000_0000,
    S_POP_LD = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = gdw_pkg::RD_NB;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        // wipe both cell maps once after reset
        cmd.clr_open = 1'b1;
        cmd.clr_vis  = 1'b1;
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          case (opcode)
            gdw_pkg::OP_LOAD: begin
              if (status.ld_in_range) state_next = S_LD_RD;
            end
            gdw_pkg::OP_START: state_next = S_ST_CLR;
            gdw_pkg::OP_NEXT:  state_next = S_NX_CHK;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_LD_RD: begin
        cmd.rd_sel = gdw_pkg::RD_LOAD;
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_commit = 1'b1;
        state_next    = S_IDLE;
      end
      S_ST_CLR: begin
        cmd.clr_vis  = 1'b1;
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_ST_RD;
      end
      S_ST_RD: begin
        cmd.rd_sel  = gdw_pkg::RD_START;
        cmd.st_init = 1'b1;
        state_next  = S_ST_EV;
      end
      S_ST_EV: begin
        if (status.unv_zero) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.st_commit = 1'b1;
        end
        state_next = S_OUT;
      end
      S_NX_CHK: begin
        if (status.done_cond) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.dir_init = 1'b1;
          state_next   = S_NX_RD;
        end
      end
      S_NX_RD: begin
        if (status.dir_end) begin
          // all directions tried: backtrack to the parent, or finish at the root
          if (status.depth_one) begin
            cmd.finish = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.pop_issue = 1'b1;
            state_next    = S_POP_LD;
          end
        end else if (!status.nb_in_range) begin
          cmd.dir_inc = 1'b1;
        end else begin
          state_next = S_NX_EV;
        end
      end
      S_NX_EV: begin
        if (status.nb_free) begin
          cmd.push_commit = 1'b1;
          state_next      = S_OUT;
        end else begin
          cmd.dir_inc = 1'b1;
          state_next  = S_NX_RD;
        end
      end
      S_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/gdw_dp.sv */
`default_nettype none
`include "grid_dfs_step_walker_macros.svh"

module gdw_dp #(
  parameter int GRID_WIDTH  = gdw_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gdw_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gdw_pkg::gdw_cmd_t          cmd,
  output gdw_pkg::gdw_status_t            status,
  input  wire logic [gdw_pkg::IDX_W-1:0]  cell_index,
  input  wire logic                       cell_open,
  input  wire logic [gdw_pkg::SX_W-1:0]   start_x,
  input  wire logic [gdw_pkg::SY_W-1:0]   start_y,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [gdw_pkg::OUT_W-1:0]       step_cell,
  output logic                            done_res
);

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_W = $clog2(CELLS);
  localparam int D_W    = $clog2(CELLS + 1);
  localparam int X_W    = $clog2(GRID_WIDTH);
  localparam int Y_W    = $clog2(GRID_HEIGHT);
  localparam int DW     = gdw_pkg::DIR_W;
  localparam int STK_W  = X_W + Y_W + DW;
  localparam int OW     = gdw_pkg::OUT_W;

  // control state
  logic [CELL_W-1:0] clr_cnt;
  logic [D_W-1:0]    depth;
  logic [D_W-1:0]    unv_cnt;
  logic [D_W-1:0]    open_cnt;
  logic              walk_done;

  // payload
  logic [CELL_W-1:0] ld_addr;
  logic              ld_open;
  logic [X_W-1:0]    sx;
  logic [Y_W-1:0]    sy;
  logic [X_W-1:0]    top_x;
  logic [Y_W-1:0]    top_y;
  logic [DW-1:0]     top_dir;
  logic [DW-1:0]     cur_dir;
  logic [OW-1:0]     res_cell;
  logic              res_done;

  // memories
  logic              open_we, open_wdata, open_q;
  logic              vis_we, vis_wdata, vis_q;
  logic [CELL_W-1:0] open_waddr, vis_waddr, rd_addr;
  logic              stk_we;
  logic [CELL_W-1:0] stk_waddr, stk_raddr;
  logic [STK_W-1:0]  stk_wdata, stk_q;

  // address and neighbour logic
  logic [X_W-1:0]    nb_x, pop_x;
  logic [Y_W-1:0]    nb_y, pop_y;
  logic [DW-1:0]     pop_dir, dir_nx;
  logic              nb_ok, stk_room, clr_last;
  logic [31:0]       idx32, sx32, sy32, sx_sat, sy_sat;
  logic [31:0]       nb_cell32, start_cell32, pop_cell32;
  logic [D_W-1:0]    depth_m1, depth_m2;

  assign idx32  = 32'(cell_index);
  assign sx32   = 32'(start_x);
  assign sy32   = 32'(start_y);
  assign sx_sat = (sx32 >= 32'(GRID_WIDTH))  ? 32'(GRID_WIDTH - 1)  : sx32;
  assign sy_sat = (sy32 >= 32'(GRID_HEIGHT)) ? 32'(GRID_HEIGHT - 1) : sy32;

  always_comb begin
    nb_x  = top_x;
    nb_y  = top_y;
    nb_ok = 1'b0;
    case (cur_dir)
      gdw_pkg::DIR_N: begin
        nb_ok = (top_y != '0);
        nb_y  = top_y - Y_W'(1);
      end
      gdw_pkg::DIR_S: begin
        nb_ok = (top_y != Y_W'(GRID_HEIGHT - 1));
        nb_y  = top_y + Y_W'(1);
      end
      gdw_pkg::DIR_W_: begin
        nb_ok = (top_x != '0);
        nb_x  = top_x - X_W'(1);
      end
      gdw_pkg::DIR_E: begin
        nb_ok = (top_x != X_W'(GRID_WIDTH - 1));
        nb_x  = top_x + X_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign pop_x   = stk_q[STK_W-1 -: X_W];
  assign pop_y   = stk_q[Y_W+DW-1 -: Y_W];
  assign pop_dir = stk_q[DW-1:0];

  assign nb_cell32    = 32'(nb_y) * 32'(GRID_WIDTH) + 32'(nb_x);
  assign start_cell32 = 32'(sy) * 32'(GRID_WIDTH) + 32'(sx);
  assign pop_cell32   = 32'(pop_y) * 32'(GRID_WIDTH) + 32'(pop_x);

  assign depth_m1 = depth - D_W'(1);
  assign depth_m2 = depth - D_W'(2);
  assign stk_room = (depth < D_W'(CELLS));
  assign dir_nx   = cur_dir + DW'(1);
  assign clr_last = (clr_cnt == CELL_W'(CELLS - 1));

  always_comb begin
    case (cmd.rd_sel)
      gdw_pkg::RD_LOAD:  rd_addr = ld_addr;
      gdw_pkg::RD_START: rd_addr = start_cell32[CELL_W-1:0];
      default:           rd_addr = nb_cell32[CELL_W-1:0];
    endcase
  end

  assign open_we    = cmd.clr_open | cmd.ld_commit;
  assign open_waddr = cmd.clr_open ? clr_cnt : ld_addr;
  assign open_wdata = cmd.clr_open ? 1'b0 : ld_open;

  assign vis_we     = cmd.clr_vis | cmd.st_commit | cmd.push_commit;
  assign vis_waddr  = cmd.clr_vis   ? clr_cnt :
                      cmd.st_commit ? start_cell32[CELL_W-1:0] :
                                      nb_cell32[CELL_W-1:0];
  assign vis_wdata  = !cmd.clr_vis;

  // the top frame lives in registers; frames below it go to memory on a push
  assign stk_we    = cmd.push_commit && stk_room;
  assign stk_waddr = depth_m1[CELL_W-1:0];
  assign stk_raddr = depth_m2[CELL_W-1:0];
  assign stk_wdata = {top_x, top_y, dir_nx};

  gdw_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open_ram (
    .clk   (clk),
    .we    (open_we),
    .waddr (open_waddr),
    .wdata (open_wdata),
    .raddr (rd_addr),
    .rdata (open_q)
  );

  gdw_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (rd_addr),
    .rdata (vis_q)
  );

  gdw_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      depth     <= '0;
      unv_cnt   <= '0;
      open_cnt  <= '0;
      walk_done <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + CELL_W'(1);
      end
      if (cmd.ld_commit && (open_q != ld_open)) begin
        open_cnt <= ld_open ? open_cnt + D_W'(1) : open_cnt - D_W'(1);
        if (!vis_q) begin
          unv_cnt <= ld_open ? unv_cnt + D_W'(1) : unv_cnt - D_W'(1);
        end
      end
      if (cmd.st_init) begin
        unv_cnt <= open_cnt;
      end
      if (cmd.st_commit) begin
        walk_done <= 1'b0;
        depth     <= D_W'(1);
        // a closed start cell is emitted without touching the count
        if (open_q && !vis_q && (unv_cnt != '0)) unv_cnt <= unv_cnt - D_W'(1);
      end
      if (cmd.push_commit) begin
        if (stk_room) depth <= depth + D_W'(1);
        if (unv_cnt != '0) unv_cnt <= unv_cnt - D_W'(1);
      end
      if (cmd.pop_issue) begin
        depth <= depth_m1;
      end
      if (cmd.finish) begin
        walk_done <= 1'b1;
        depth     <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ld_addr <= idx32[CELL_W-1:0];
      ld_open <= cell_open;
      sx      <= sx_sat[X_W-1:0];
      sy      <= sy_sat[Y_W-1:0];
    end
    if (cmd.dir_init) cur_dir <= top_dir;
    if (cmd.dir_inc)  cur_dir <= dir_nx;
    if (cmd.st_commit) begin
      top_x    <= sx;
      top_y    <= sy;
      top_dir  <= gdw_pkg::DIR_N;
      res_cell <= start_cell32[OW-1:0];
      res_done <= 1'b0;
    end
    if (cmd.push_commit) begin
      if (stk_room) begin
        top_x   <= nb_x;
        top_y   <= nb_y;
        top_dir <= gdw_pkg::DIR_N;
      end else begin
        top_dir <= dir_nx;
      end
      res_cell <= nb_cell32[OW-1:0];
      res_done <= 1'b0;
    end
    if (cmd.pop_load) begin
      top_x    <= pop_x;
      top_y    <= pop_y;
      top_dir  <= pop_dir;
      res_cell <= pop_cell32[OW-1:0];
      res_done <= 1'b0;
    end
    if (cmd.finish) begin
      res_cell <= '0;
      res_done <= 1'b1;
    end
    if (cmd.out_load) begin
      step_cell <= res_cell;
      done_res  <= res_done;
    end
  end

  always_comb begin
    status.ld_in_range = (idx32 < 32'(CELLS));
    status.clr_last    = clr_last;
    status.done_cond   = walk_done || (depth == '0) || (unv_cnt == '0);
    status.dir_end     = (cur_dir == gdw_pkg::DIR_END);
    status.depth_one   = (depth == D_W'(1));
    status.nb_in_range = nb_ok;
    status.nb_free     = open_q && !vis_q;
    status.unv_zero    = (unv_cnt == '0);
    status.out_free    = !out_valid || out_ready;
  end

  `GDW_ASSERT_NOW(a_done_means_empty, 1'b1, walk_done == (depth == '0))
  `GDW_ASSERT_NOW(a_depth_bound, 1'b1, depth <= D_W'(CELLS))
  `GDW_ASSERT_NOW(a_unv_le_open, 1'b1, unv_cnt <= open_cnt)
  `GDW_ASSERT_NOW(a_push_needs_free, cmd.push_commit, open_q && !vis_q)
  `GDW_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid)

endmodule

`default_nettype wire
